// ----- design/assert_macros.svh -----
// assertion helper macros for the ascii tile block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every clock edge outside reset
`define CHK_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check an implication that also holds during reset
`define CHK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/itaa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaa_pkg
// shared types and constants of the tile average to ascii block
// ----------------------------------------------------------------------------
package itaa_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;

    localparam logic [2:0] REG_IMG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_TILE_COLS   = 3'd2;
    localparam logic [2:0] REG_TILE_ROWS   = 3'd3;
    localparam logic [2:0] REG_TILE_W_FX   = 3'd4;
    localparam logic [2:0] REG_TILE_H_FX   = 3'd5;
    localparam logic [2:0] REG_CHANNELS    = 3'd6;
    localparam logic [2:0] REG_LEVEL_COUNT = 3'd7;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 28;

    // most tile columns, and the bits of a column index
    localparam int MAX_COLS = 256;
    localparam int COL_W    = $clog2(MAX_COLS);

    typedef struct packed {
        logic       cmd;
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic [6:0] level_slot;
        logic [7:0] level_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_image;
    } out_item_t;

    // work handed from front to back
    typedef struct packed {
        logic        is_load;
        logic [6:0]  slot;
        logic [7:0]  lchar;
        logic [7:0]  gray;
        logic [COL_W-1:0] col;
        logic        col_done;
        logic        row_last;
        logic        last_x;
        logic        last_y;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ACC,
        BK_DIV,
        BK_IDX,
        BK_LOOK,
        BK_EMIT,
        BK_NL
    } bk_state_t;

    typedef struct packed {
        logic [12:0] w;
        logic [12:0] h;
        logic [10:0] cols;
        logic [12:0] rows;
        logic [27:0] tw;
        logic [27:0] th;
        logic        color;
        logic [7:0]  levels;
    } cfg_t;

endpackage

// ----- design/image_tile_average_to_ascii_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_tile_average_to_ascii_top
// raster pixels in, ascii art characters out
// ----------------------------------------------------------------------------
// A table load is written to the table from the back's idle state, so loads
// can follow back to back. A pixel inside a tile goes through the back's take
// and accumulate steps; the front holds one job ahead, and stalls its input to
// recompute the column edge when a tile column is crossed or a pixel row ends,
// and also the row edge when that pixel row ends a tile row. A pixel that
// finishes a tile runs a bit-serial 32-step divide of the tile sum by its pixel
// count, then index, table read and output of the character; at the end of a
// tile row a newline follows once the character is taken. Output stalls hold
// the back. A configuration write below index 8 restarts the image with a
// registered restart, then column and row edge setup, holding off the input.
module image_tile_average_to_ascii_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [itaa_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [itaa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  itaa_pkg::in_item_t            s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output itaa_pkg::out_item_t           m_item
);
    // register file, with the effective clamped values derived
    logic [12:0] w_reg, h_reg, rows_reg;
    logic [8:0]  cols_reg;
    logic [27:0] tw_reg, th_reg;
    logic [2:0]  ch_reg;
    logic [7:0]  lv_reg;
    logic        rst_pend_reg;
    itaa_pkg::cfg_t cfg;
    itaa_pkg::job_t job;
    logic job_valid, job_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= 13'd1; h_reg <= 13'd1; cols_reg <= 9'd1; rows_reg <= 13'd1;
            tw_reg <= 28'd65536; th_reg <= 28'd65536; ch_reg <= 3'd3; lv_reg <= 8'd1;
            rst_pend_reg <= 1'b1;
        end else begin
            rst_pend_reg <= cfg_we && cfg_index < 4'd8;
            if (cfg_we) begin
                case (cfg_index)
                    4'(itaa_pkg::REG_IMG_WIDTH):   w_reg <= cfg_data[12:0];
                    4'(itaa_pkg::REG_IMG_HEIGHT):  h_reg <= cfg_data[12:0];
                    4'(itaa_pkg::REG_TILE_COLS):   cols_reg <= cfg_data[8:0];
                    4'(itaa_pkg::REG_TILE_ROWS):   rows_reg <= cfg_data[12:0];
                    4'(itaa_pkg::REG_TILE_W_FX):   tw_reg <= cfg_data;
                    4'(itaa_pkg::REG_TILE_H_FX):   th_reg <= cfg_data;
                    4'(itaa_pkg::REG_CHANNELS):    ch_reg <= cfg_data[2:0];
                    4'(itaa_pkg::REG_LEVEL_COUNT): lv_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // clamp to legal ranges
    always_comb begin
        cfg.w = (w_reg == 13'd0) ? 13'd1 : (w_reg > 13'd4096 ? 13'd4096 : w_reg);
        cfg.h = (h_reg == 13'd0) ? 13'd1 : (h_reg > 13'd4096 ? 13'd4096 : h_reg);
        cfg.cols = (cols_reg == 9'd0) ? 11'd1 :
                   (cols_reg > 9'(itaa_pkg::MAX_COLS) && itaa_pkg::MAX_COLS < 512
                    ? 11'(itaa_pkg::MAX_COLS) : {2'd0, cols_reg});
        cfg.rows = (rows_reg == 13'd0) ? 13'd1 : (rows_reg > 13'd4096 ? 13'd4096 : rows_reg);
        cfg.tw = tw_reg; cfg.th = th_reg;
        cfg.color = ch_reg > 3'd2;
        cfg.levels = (lv_reg == 8'd0) ? 8'd1 : (lv_reg > 8'd128 ? 8'd128 : lv_reg);
    end

    // column tile index travels with the job
    itaa_front u_front (
        .aclk(aclk), .aresetn(aresetn), .restart(rst_pend_reg), .cfg(cfg),
        .in_valid(s_valid), .in_ready(s_ready), .in_item(s_item),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    itaa_back u_back (
        .aclk(aclk), .aresetn(aresetn), .restart(rst_pend_reg), .cfg(cfg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(m_valid), .out_ready(m_ready), .out_item(m_item)
    );
endmodule

// ----- design/itaa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaa_front
// tracks raster position and tile edges, converts to gray, queues jobs
// ----------------------------------------------------------------------------
module itaa_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               restart,
    input  itaa_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  itaa_pkg::in_item_t in_item,
    output logic               job_valid,
    input  logic               job_ready,
    output itaa_pkg::job_t     job
);
    localparam int DIM_W = 13;
    // edge computing: the column edge, then the row edge, recomputed after a restart, a tile column change or a row end
    logic [DIM_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [10:0] ct_reg, ct_next;
    logic [DIM_W-1:0] rt_reg, rt_next;
    logic [DIM_W-1:0] cedge_reg, cedge_next, redge_reg, redge_next;
    logic busy_reg, busy_next;       // edges being recomputed
    logic need_col_reg, need_col_next, need_row_reg, need_row_next;
    logic [DIM_W:0] eidx;
    logic [41:0] mult;
    logic [DIM_W-1:0] edge_res;
    logic do_col;
    logic [7:0] gray;
    logic [15:0] wsum;
    logic [31:0] gmul;
    itaa_pkg::job_t job_reg, job_next;
    logic jv_reg, jv_next;
    logic fire;
    logic lx, cd, rl, ly;

    // pick which edge to recompute: column first
    assign do_col = need_col_reg;
    always_comb begin
        if (do_col) eidx = {{(DIM_W-10){1'b0}}, ct_reg} + 1'b1;
        else        eidx = {1'b0, rt_reg} + 1'b1;
    end
    // index times step, with the integer part checked against the image size
    assign mult = {{(42-DIM_W-1){1'b0}}, eidx} * {14'd0, (do_col ? cfg.tw : cfg.th)};
    always_comb begin
        logic last;
        logic [DIM_W-1:0] lim;
        logic [25:0] e;
        last = do_col ? ({{(DIM_W-10){1'b0}}, ct_reg} + 1'b1
                         >= {{(DIM_W-10){1'b0}}, cfg.cols})
                      : ({1'b0, rt_reg} + 1'b1 >= {1'b0, cfg.rows});
        lim = do_col ? cfg.w : cfg.h;
        e = mult[41:16];
        if (last || e > {13'd0, lim}) edge_res = lim;
        else edge_res = e[DIM_W-1:0];
    end

    // gray from channels, divide by 100 as a reciprocal multiply
    assign wsum = 16'd30 * in_item.chan0 + 16'd59 * in_item.chan1 + 16'd11 * in_item.chan2;
    assign gmul = {16'd0, wsum} * 32'd41944;
    always_comb begin
        logic [15:0] q;
        logic [15:0] r;
        q = {6'd0, gmul[31:22]};
        r = wsum - 16'(q * 16'd100);
        if (r >= 16'd100) q = q + 1'b1;
        gray = cfg.color ? q[7:0] : in_item.chan0;
    end

    assign in_ready = !busy_reg && (!jv_reg || job_ready) && !restart;
    assign fire = in_valid && in_ready;
    assign lx = {px_reg} + 1'b1 >= cfg.w;
    assign cd = lx || (px_reg + 1'b1 >= cedge_reg);
    assign ly = py_reg + 1'b1 >= cfg.h;
    assign rl = ly || (py_reg + 1'b1 >= redge_reg);

    always_comb begin
        px_next = px_reg; py_next = py_reg; ct_next = ct_reg; rt_next = rt_reg;
        cedge_next = cedge_reg; redge_next = redge_reg;
        busy_next = busy_reg; need_col_next = need_col_reg; need_row_next = need_row_reg;
        jv_next = jv_reg && !job_ready;
        job_next = job_reg;
        if (restart) begin
            px_next = '0; py_next = '0; ct_next = '0; rt_next = '0;
            busy_next = 1'b1; need_col_next = 1'b1; need_row_next = 1'b1;
        end else if (busy_reg) begin
            if (do_col) begin
                cedge_next = edge_res; need_col_next = 1'b0;
                busy_next = need_row_reg;
            end else begin
                redge_next = edge_res; need_row_next = 1'b0;
                busy_next = 1'b0;
            end
        end else if (fire) begin
            jv_next = 1'b1;
            job_next.is_load = (in_item.cmd == itaa_pkg::CMD_LOAD);
            job_next.slot = in_item.level_slot;
            job_next.lchar = in_item.level_char;
            job_next.gray = gray;
            job_next.col = ct_reg[itaa_pkg::COL_W-1:0];
            job_next.col_done = cd; job_next.row_last = rl;
            job_next.last_x = lx; job_next.last_y = ly;
            if (in_item.cmd == itaa_pkg::CMD_PIXEL) begin
                if (cd && !lx && ({{(DIM_W-10){1'b0}}, ct_reg} + 1'b1
                                  < {{(DIM_W-10){1'b0}}, cfg.cols})
                    && ct_reg < 11'(itaa_pkg::MAX_COLS - 1)) begin
                    ct_next = ct_reg + 1'b1;
                    busy_next = 1'b1; need_col_next = 1'b1;
                end
                if (lx) begin
                    px_next = '0; ct_next = '0;
                    busy_next = 1'b1; need_col_next = 1'b1;
                    py_next = py_reg + 1'b1;
                    if (rl) begin
                        need_row_next = 1'b1;
                        if (ly) begin
                            py_next = '0; rt_next = '0;
                        end else if (rt_reg + 1'b1 < cfg.rows) begin
                            rt_next = rt_reg + 1'b1;
                        end
                    end
                end else begin
                    px_next = px_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg <= '0; py_reg <= '0; ct_reg <= '0; rt_reg <= '0;
            busy_reg <= 1'b1; need_col_reg <= 1'b1; need_row_reg <= 1'b1;
            jv_reg <= 1'b0;
        end else begin
            px_reg <= px_next; py_reg <= py_next; ct_reg <= ct_next; rt_reg <= rt_next;
            busy_reg <= busy_next; need_col_reg <= need_col_next;
            need_row_reg <= need_row_next; jv_reg <= jv_next;
        end
        cedge_reg <= cedge_next; redge_reg <= redge_next; job_reg <= job_next;
    end

    assign job_valid = jv_reg;
    assign job = job_reg;
endmodule

// ----- design/itaa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaa_back
// tile sums, serial average divide, table lookup and result output
// ----------------------------------------------------------------------------
module itaa_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                restart,
    input  itaa_pkg::cfg_t      cfg,
    input  logic                job_valid,
    output logic                job_ready,
    input  itaa_pkg::job_t      job,
    output logic                out_valid,
    input  logic                out_ready,
    output itaa_pkg::out_item_t out_item
);
    localparam int COLS = itaa_pkg::MAX_COLS;
    localparam int CW = itaa_pkg::COL_W;
    itaa_pkg::bk_state_t st_reg, st_next;
    logic [31:0] sum_mem [COLS];
    logic [24:0] cnt_mem [COLS];
    logic [7:0]  lvl_mem [128];
    logic [COLS-1:0] vld_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [31:0] sum_rd; logic [24:0] cnt_rd;
    itaa_pkg::job_t j_reg, j_next;
    logic [31:0] rem_reg, rem_next; logic [31:0] quo_reg, quo_next;
    logic [5:0] bit_reg, bit_next;
    logic [31:0] s_reg, s_next; logic [24:0] n_reg, n_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] chr_reg;
    logic ov_reg, ov_next; itaa_pkg::out_item_t oi_reg, oi_next;
    logic [15:0] prod;
    logic [31:0] rsh;
    logic wr_acc, wr_clr, look;
    logic [CW-1:0] col_now;

    assign col_now = job.col;
    assign job_ready = (st_reg == itaa_pkg::BK_IDLE) && !restart;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            itaa_pkg::BK_IDLE: if (job_valid && job_ready && !job.is_load) st_next = itaa_pkg::BK_ACC;
            itaa_pkg::BK_ACC: begin
                if (j_reg.col_done && j_reg.row_last) st_next = itaa_pkg::BK_DIV;
                else if (j_reg.last_x && j_reg.row_last) st_next = itaa_pkg::BK_NL;
                else st_next = itaa_pkg::BK_IDLE;
            end
            itaa_pkg::BK_DIV: if (bit_reg == 6'd0) st_next = itaa_pkg::BK_IDX;
            itaa_pkg::BK_IDX:  st_next = itaa_pkg::BK_LOOK;
            itaa_pkg::BK_LOOK: st_next = itaa_pkg::BK_EMIT;
            itaa_pkg::BK_EMIT: if (!ov_reg) st_next = (j_reg.last_x && j_reg.row_last)
                ? itaa_pkg::BK_NL : itaa_pkg::BK_IDLE;
            itaa_pkg::BK_NL: if (!ov_reg) st_next = itaa_pkg::BK_IDLE;
            default: st_next = itaa_pkg::BK_IDLE;
        endcase
        if (restart) st_next = itaa_pkg::BK_IDLE;
    end

    assign rsh = {rem_reg[30:0], s_reg[bit_reg[4:0]]};
    assign prod = {8'd0, (quo_reg > 32'd255 ? 8'd255 : quo_reg[7:0])} * {8'd0, cfg.levels - 8'd1};

    always_comb begin
        j_next = j_reg; col_next = col_reg;
        rem_next = rem_reg; quo_next = quo_reg; bit_next = bit_reg;
        s_next = s_reg; n_next = n_reg; idx_next = idx_reg;
        ov_next = ov_reg && !out_ready; oi_next = oi_reg;
        wr_acc = 1'b0; wr_clr = 1'b0; look = 1'b0;
        case (st_reg)
            itaa_pkg::BK_IDLE: if (job_valid && job_ready) begin
                j_next = job; col_next = col_now;
            end
            itaa_pkg::BK_ACC: begin
                wr_acc = 1'b1;
                s_next = (vld_reg[col_reg] ? sum_rd : 32'd0) + {24'd0, j_reg.gray};
                n_next = (vld_reg[col_reg] ? cnt_rd : 25'd0) + 25'd1;
                rem_next = '0; quo_next = '0; bit_next = 6'd31;
                if (j_reg.col_done && j_reg.row_last) wr_clr = 1'b1;
            end
            itaa_pkg::BK_DIV: begin
                if (rsh >= {7'd0, n_reg}) begin
                    rem_next = rsh - {7'd0, n_reg};
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = rsh;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                bit_next = bit_reg - 6'd1;
            end
            itaa_pkg::BK_IDX: begin
                idx_next = 8'((32'(prod) * 32'd257 + 32'd257) >> 16);
                if ({16'd0, prod} < 32'(idx_next) * 32'd255) idx_next = idx_next - 8'd1;
                if (idx_next > 8'd127) idx_next = 8'd127;
            end
            itaa_pkg::BK_LOOK: look = 1'b1;
            itaa_pkg::BK_EMIT: if (!ov_reg) begin
                ov_next = 1'b1; oi_next.out_char = chr_reg; oi_next.end_of_image = 1'b0;
            end
            itaa_pkg::BK_NL: if (!ov_reg) begin
                ov_next = 1'b1; oi_next.out_char = itaa_pkg::NEWLINE_CHAR;
                oi_next.end_of_image = j_reg.last_y;
            end
            default: ;
        endcase
        if (st_reg == itaa_pkg::BK_DIV && bit_reg == 6'd0) bit_next = 6'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= itaa_pkg::BK_IDLE; ov_reg <= 1'b0; vld_reg <= '0;
        end else begin
            st_reg <= st_next; ov_reg <= ov_next;
            if (restart) vld_reg <= '0;
            else if (wr_acc) vld_reg[col_reg] <= !wr_clr;
        end
        j_reg <= j_next; col_reg <= col_next; rem_reg <= rem_next; quo_reg <= quo_next;
        bit_reg <= bit_next; s_reg <= s_next; n_reg <= n_next; idx_reg <= idx_next;
        oi_reg <= oi_next;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (wr_acc) begin
            sum_mem[col_reg] <= s_next;
            cnt_mem[col_reg] <= n_next;
        end
        sum_rd <= sum_mem[col_next];
        cnt_rd <= cnt_mem[col_next];
    end
    always_ff @(posedge aclk) begin
        if (st_reg == itaa_pkg::BK_IDLE && job_valid && job_ready && job.is_load)
            lvl_mem[job.slot] <= job.lchar;
        if (look) chr_reg <= lvl_mem[idx_reg[6:0]];
    end

    assign out_valid = ov_reg;
    assign out_item = oi_reg;
endmodule

// ----- design/itaa_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// itaa_checker
// port level checks of the tile average to ascii block
// ----------------------------------------------------------------------------
module itaa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input itaa_pkg::out_item_t m_item
);
    `CHK_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "output valid after reset")
    `CHK_IMPL(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_item), "item dropped")
    `CHK_IMPL(a_eoi_nl, aclk, aresetn, m_valid && m_item.end_of_image |-> m_item.out_char == itaa_pkg::NEWLINE_CHAR, "end of image not on newline")
    `CHK_IMPL(a_reset_ready, aclk, aresetn, $rose(aresetn) |-> !s_ready, "ready before edge setup")
endmodule

bind image_tile_average_to_ascii_top itaa_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tile average to ascii block
// ----------------------------------------------------------------------------
// Table loads and pixels are driven over the valid/ready input channel. A
// behavioral model of the tile averaging inside the scoreboard predicts each
// character and newline, and the output channel is checked item by item.
// Several image and tile settings are run, including the register extremes.
// ----------------------------------------------------------------------------
module tb;
    localparam int AW = itaa_pkg::CFG_ADDR_W;

    // ascii art predictor and queue of pending characters
    class ascii_scoreboard;
        logic [12:0] img_w, img_h;
        logic [8:0]  n_cols;
        logic [12:0] n_rows;
        logic [27:0] tw_fx, th_fx;
        logic [2:0]  chans;
        logic [7:0]  n_levels;
        int unsigned px, py, col, row, col_edge, row_edge;
        int unsigned col_sum[256];
        int unsigned col_cnt[256];
        logic [7:0]  glyphs[128];
        itaa_pkg::out_item_t pending_chars[$];
        int          errors;

        function new();
            img_w = 1; img_h = 1; n_cols = 1; n_rows = 1;
            tw_fx = 65536; th_fx = 65536; chans = 3; n_levels = 1;
            errors = 0;
            foreach (glyphs[i]) glyphs[i] = 8'd0;
            restart();
        endfunction

        function int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function int unsigned w_eff(); return clampv(img_w, 1, 4096); endfunction
        function int unsigned h_eff(); return clampv(img_h, 1, 4096); endfunction

        function int unsigned edge_of(int unsigned i, int unsigned cnt,
                                      logic [27:0] step, int unsigned lim);
            longint unsigned e;
            if (i + 1 >= cnt) return lim;
            e = (longint'(i + 1) * longint'(step)) >> 16;
            return e > lim ? lim : int'(e);
        endfunction

        function int unsigned col_edge_of(int unsigned i);
            return edge_of(i, clampv(n_cols, 1, 256), tw_fx, w_eff());
        endfunction

        function int unsigned row_edge_of(int unsigned j);
            return edge_of(j, clampv(n_rows, 1, 4096), th_fx, h_eff());
        endfunction

        function void restart();
            px = 0; py = 0; col = 0; row = 0;
            foreach (col_sum[i]) begin
                col_sum[i] = 0;
                col_cnt[i] = 0;
            end
            col_edge = col_edge_of(0);
            row_edge = row_edge_of(0);
        endfunction

        function void write_reg(logic [2:0] idx, logic [27:0] v);
            case (idx)
                itaa_pkg::REG_IMG_WIDTH:   img_w = v[12:0];
                itaa_pkg::REG_IMG_HEIGHT:  img_h = v[12:0];
                itaa_pkg::REG_TILE_COLS:   n_cols = v[8:0];
                itaa_pkg::REG_TILE_ROWS:   n_rows = v[12:0];
                itaa_pkg::REG_TILE_W_FX:   tw_fx = v;
                itaa_pkg::REG_TILE_H_FX:   th_fx = v;
                itaa_pkg::REG_CHANNELS:    chans = v[2:0];
                itaa_pkg::REG_LEVEL_COUNT: n_levels = v[7:0];
                default: ;
            endcase
            restart();
        endfunction

        function void note_input(itaa_pkg::in_item_t it);
            int unsigned gray, c, avg, lv;
            bit last_x, col_done, row_last;
            itaa_pkg::out_item_t r;
            if (it.cmd == itaa_pkg::CMD_LOAD) begin
                glyphs[it.level_slot] = it.level_char;
                return;
            end
            c = col > 255 ? 255 : col;
            gray = chans <= 2 ? it.chan0
                 : (30 * it.chan0 + 59 * it.chan1 + 11 * it.chan2) / 100;
            col_sum[c] += gray;
            col_cnt[c] += 1;
            last_x = px + 1 >= w_eff();
            col_done = last_x || (px + 1 >= col_edge);
            row_last = (py + 1 >= h_eff()) || (py + 1 >= row_edge);
            if (col_done) begin
                if (row_last) begin
                    lv = clampv(n_levels, 1, 128);
                    avg = col_cnt[c] ? col_sum[c] / col_cnt[c] : 0;
                    if (avg > 255) avg = 255;
                    r.out_char = glyphs[avg * (lv - 1) / 255];
                    r.end_of_image = 1'b0;
                    pending_chars.push_back(r);
                    col_sum[c] = 0;
                    col_cnt[c] = 0;
                end
                if (!last_x && c + 1 < clampv(n_cols, 1, 256)) begin
                    col = c + 1;
                    col_edge = col_edge_of(col);
                end
            end
            if (last_x) begin
                if (row_last) begin
                    r.out_char = itaa_pkg::NEWLINE_CHAR;
                    r.end_of_image = (py + 1 >= h_eff());
                    pending_chars.push_back(r);
                end
                px = 0; col = 0;
                col_edge = col_edge_of(0);
                if (row_last) begin
                    if (py + 1 >= h_eff()) begin
                        py = 0; row = 0;
                    end else begin
                        py = py + 1;
                        if (row + 1 < clampv(n_rows, 1, 4096)) row++;
                    end
                    row_edge = row_edge_of(row);
                end else begin
                    py = py + 1;
                end
            end else begin
                px = px + 1;
            end
        endfunction

        function void check_output(itaa_pkg::out_item_t got);
            itaa_pkg::out_item_t want;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected output %h", $time, got);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (got.out_char !== want.out_char) begin
                $display("%0t: out_char expected %0d actual %0d", $time,
                         want.out_char, got.out_char);
                errors++;
            end
            if (got.end_of_image !== want.end_of_image) begin
                $display("%0t: end_of_image expected %0d actual %0d", $time,
                         want.end_of_image, got.end_of_image);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [itaa_pkg::CFG_ADDR_W-1:0] cfg_index = '0;
    logic [itaa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    itaa_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    itaa_pkg::out_item_t m_item;

    ascii_scoreboard sb = new();
    bit quiet_tail = 1'b0;    // no idling near the end
    int unsigned cycle_count = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    image_tile_average_to_ascii_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    // output side: check at the rising edge, stall in bursts at the falling edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_output(m_item);
    end

    initial begin
        int burst;
        @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                burst = $urandom_range(1, 16);
                m_ready <= 1'b0;
                repeat (burst) @(negedge aclk);
            end
        end
    end

    // cycle limit: stop and fail a run that hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("** image_tile_average_to_ascii_top: FAILED **");
            $finish;
        end
    end

    // send one item, with an optional idle burst ahead of it
    task automatic send_item(itaa_pkg::in_item_t it);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
        @(negedge aclk);
    endtask

    task automatic send_pixel();
        itaa_pkg::in_item_t it;
        it = itaa_pkg::in_item_t'({$urandom, $urandom});
        it.cmd = itaa_pkg::CMD_PIXEL;
        send_item(it);
    endtask

    task automatic send_load(logic [6:0] slot, logic [7:0] ch);
        itaa_pkg::in_item_t it;
        it = itaa_pkg::in_item_t'({$urandom, $urandom});
        it.cmd = itaa_pkg::CMD_LOAD;
        it.level_slot = slot;
        it.level_char = ch;
        send_item(it);
    endtask

    // wait for the queue to drain, then let the last tile divide settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_chars.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [27:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= AW'(idx);
        cfg_data  <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, v);
        repeat (4) @(negedge aclk);
    endtask

    // program a full setting; tile sizes are derived from the image size
    task automatic setup(int unsigned w, int unsigned h, int unsigned cols,
                         int unsigned rows, int unsigned ch, int unsigned lv);
        write_reg(itaa_pkg::REG_IMG_WIDTH, 28'(w));
        write_reg(itaa_pkg::REG_IMG_HEIGHT, 28'(h));
        write_reg(itaa_pkg::REG_TILE_COLS, 28'(cols));
        write_reg(itaa_pkg::REG_TILE_ROWS, 28'(rows));
        write_reg(itaa_pkg::REG_TILE_W_FX, 28'((w << 16) / cols));
        write_reg(itaa_pkg::REG_TILE_H_FX, 28'((h << 16) / rows));
        write_reg(itaa_pkg::REG_CHANNELS, 28'(ch));
        write_reg(itaa_pkg::REG_LEVEL_COUNT, 28'(lv));
    endtask

    initial begin
        int unsigned w, h, cols, rows, n;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fill the whole table so no unwritten entry is ever read
        for (int i = 0; i < 128; i++) send_load(i[6:0], 8'($urandom));
        drain();

        // directed: 4x2 image, 4 columns of one pixel, extremes of channels
        setup(4, 2, 4, 2, 3, 128);
        send_load(7'd127, 8'hff);
        send_load(7'd0, 8'h00);
        for (int i = 0; i < 8; i++) begin
            itaa_pkg::in_item_t it;
            it = '0;
            it.cmd = itaa_pkg::CMD_PIXEL;
            if (i[0]) begin
                it.chan0 = 8'hff; it.chan1 = 8'hff; it.chan2 = 8'hff;
            end
            send_item(it);
        end
        drain();

        // sub-pixel tiles and more tiles than pixels, one level, gray mode
        setup(3, 3, 8, 6, 1, 1);
        write_reg(itaa_pkg::REG_TILE_W_FX, 28'd65536);
        write_reg(itaa_pkg::REG_TILE_H_FX, 28'd20000);
        repeat (9) send_pixel();
        drain();

        // largest tile sizes, gray+alpha, zero channels
        setup(5, 2, 2, 1, 2, 2);
        write_reg(itaa_pkg::REG_TILE_W_FX, 28'hfffffff);
        write_reg(itaa_pkg::REG_TILE_H_FX, 28'hfffffff);
        repeat (10) send_pixel();
        drain();
        write_reg(itaa_pkg::REG_CHANNELS, 28'd0);
        repeat (10) send_pixel();
        drain();

        // widest image with full 256 columns, one row only
        setup(4096, 1, 256, 1, 4, 128);
        write_reg(itaa_pkg::REG_TILE_ROWS, 28'd4096);
        write_reg(itaa_pkg::REG_IMG_HEIGHT, 28'd1);
        for (int i = 0; i < 300; i++) send_pixel();
        drain();

        // random images, mostly small, with a table reload now and then
        n = 0;
        while (n < 250) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            cols = $urandom_range(1, w);
            rows = $urandom_range(1, h);
            setup(w, h, cols, rows, $urandom_range(0, 7), $urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(itaa_pkg::REG_TILE_W_FX, 28'($urandom_range(16384, 200000)));
                write_reg(itaa_pkg::REG_TILE_H_FX, 28'($urandom_range(16384, 200000)));
            end
            if (n > 180) quiet_tail = 1'b1;
            repeat ($urandom_range(1, 3) * w * h) begin
                if ($urandom_range(0, 19) == 0) send_load(7'($urandom), 8'($urandom));
                else send_pixel();
                n++;
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("** image_tile_average_to_ascii_top: PASSED **");
        end else begin
            $display("** image_tile_average_to_ascii_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- image_tile_average_to_ascii_top.f -----
+incdir+design
design/itaa_pkg.sv
design/itaa_front.sv
design/itaa_back.sv
design/image_tile_average_to_ascii_top.sv
design/itaa_checker.sv
verif/tb.sv
